FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module of the phase angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define IQPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iq_phase_angle property failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define IQPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iq_phase_angle property failed");

`endif

FILE: hdl/iqpa_pkg.sv
// Package with the constants, types and arctangent table of the phase angle block.
package iqpa_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 14;
    localparam int CORDIC_GUARD     = 8;
    localparam int ATAN_TABLE_LEN   = 24;
    localparam int ANGLE_W          = 23;
    localparam int ROUND_SHIFT      = 7;
    localparam int PHASE_W          = 16;

    localparam logic signed [PHASE_W-1:0] PI_Q13      = 16'sd25736;
    localparam logic signed [PHASE_W-1:0] HALF_PI_Q13 = 16'sd12868;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    // Side information that travels with each sample down the pipeline.
    typedef struct packed {
        logic last;
        logic neg_i;
        logic neg_q;
        logic i_zero;
        logic q_zero;
    } t_tag;

    // atan(2^-k) in radians scaled by 2^20, rounded to nearest.
    function automatic t_angle atan_entry(input int unsigned k);
        t_angle v;
        case (k)
            0:       v = 23'sd823550;
            1:       v = 23'sd486170;
            2:       v = 23'sd256879;
            3:       v = 23'sd130396;
            4:       v = 23'sd65451;
            5:       v = 23'sd32757;
            6:       v = 23'sd16383;
            7:       v = 23'sd8192;
            8:       v = 23'sd4096;
            9:       v = 23'sd2048;
            10:      v = 23'sd1024;
            11:      v = 23'sd512;
            12:      v = 23'sd256;
            13:      v = 23'sd128;
            14:      v = 23'sd64;
            15:      v = 23'sd32;
            16:      v = 23'sd16;
            17:      v = 23'sd8;
            18:      v = 23'sd4;
            19:      v = 23'sd2;
            20:      v = 23'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/iqpa_prep.sv
// Input stage: takes magnitudes of the sample and flags its quadrant and axis cases.
module iqpa_prep #(
    parameter int SAMPLE_WIDTH = iqpa_pkg::SAMPLE_WIDTH_DEF,
    parameter int VEC_W        = SAMPLE_WIDTH + iqpa_pkg::CORDIC_GUARD + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    input  logic                           i_last,
    output logic                           o_valid,
    output logic signed [VEC_W-1:0]        o_x,
    output logic signed [VEC_W-1:0]        o_y,
    output iqpa_pkg::t_tag                 o_tag
);
    import iqpa_pkg::*;

    localparam int MAG_W = SAMPLE_WIDTH + 1;

    logic [MAG_W-1:0]         mag_i;
    logic [MAG_W-1:0]         mag_q;
    logic signed [VEC_W-1:0]  n_x;
    logic signed [VEC_W-1:0]  n_y;
    t_tag                     n_tag;
    logic                     r_valid;
    logic signed [VEC_W-1:0]  r_x;
    logic signed [VEC_W-1:0]  r_y;
    t_tag                     r_tag;

    // One extra bit keeps the magnitude of the most negative sample exact.
    always_comb begin
        mag_i = i_sample_i[SAMPLE_WIDTH-1] ? MAG_W'(-{i_sample_i[SAMPLE_WIDTH-1], i_sample_i})
                                           : {1'b0, i_sample_i};
        mag_q = i_sample_q[SAMPLE_WIDTH-1] ? MAG_W'(-{i_sample_q[SAMPLE_WIDTH-1], i_sample_q})
                                           : {1'b0, i_sample_q};
        n_x = $signed(VEC_W'({mag_i, {CORDIC_GUARD{1'b0}}}));
        n_y = $signed(VEC_W'({mag_q, {CORDIC_GUARD{1'b0}}}));
        n_tag.last   = i_last;
        n_tag.neg_i  = i_sample_i[SAMPLE_WIDTH-1];
        n_tag.neg_q  = i_sample_q[SAMPLE_WIDTH-1];
        n_tag.i_zero = (i_sample_i == '0);
        n_tag.q_zero = (i_sample_q == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_tag   = r_tag;

endmodule

FILE: hdl/iqpa_cordic_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift.
module iqpa_cordic_stage #(
    parameter int VEC_W = iqpa_pkg::SAMPLE_WIDTH_DEF + iqpa_pkg::CORDIC_GUARD + 2,
    parameter int STEP  = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [VEC_W-1:0] i_x,
    input  logic signed [VEC_W-1:0] i_y,
    input  iqpa_pkg::t_angle        i_z,
    input  iqpa_pkg::t_tag          i_tag,
    output logic                    o_valid,
    output logic signed [VEC_W-1:0] o_x,
    output logic signed [VEC_W-1:0] o_y,
    output iqpa_pkg::t_angle        o_z,
    output iqpa_pkg::t_tag          o_tag
);
    import iqpa_pkg::*;

    localparam t_angle STEP_ANGLE = atan_entry(STEP);

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [VEC_W-1:0] n_x;
    logic signed [VEC_W-1:0] n_y;
    t_angle                  n_z;
    logic                    r_valid;
    logic signed [VEC_W-1:0] r_x;
    logic signed [VEC_W-1:0] r_y;
    t_angle                  r_z;
    t_tag                    r_tag;

    // Arithmetic shifts floor toward minus infinity; both use the old x and y.
    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!i_y[VEC_W-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + STEP_ANGLE;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

FILE: hdl/iqpa_fold.sv
// Output stage: rounds the CORDIC angle to Q2.13 and folds it into the sample's quadrant.
module iqpa_fold (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  iqpa_pkg::t_angle                       i_z,
    input  iqpa_pkg::t_tag                         i_tag,
    output logic                                   o_valid,
    output logic signed [iqpa_pkg::PHASE_W-1:0]    o_phase,
    output logic                                   o_last
);
    import iqpa_pkg::*;

    localparam int RND_W = ANGLE_W - ROUND_SHIFT;

    t_angle                    z_pos;
    t_angle                    z_rnd;
    logic [RND_W-1:0]          a_full;
    logic signed [PHASE_W-1:0] a;
    logic signed [PHASE_W-1:0] n_phase;
    logic                      r_valid;
    logic signed [PHASE_W-1:0] r_phase;
    logic                      r_last;

    always_comb begin
        z_pos  = i_z[ANGLE_W-1] ? '0 : i_z;
        z_rnd  = z_pos + t_angle'(1 << (ROUND_SHIFT - 1));
        a_full = z_rnd[ANGLE_W-1:ROUND_SHIFT];
        if (a_full > RND_W'(HALF_PI_Q13)) begin
            a = HALF_PI_Q13;
        end else begin
            a = $signed(PHASE_W'(a_full));
        end

        // Samples on an axis take their exact angle; others fold by quadrant.
        if (i_tag.q_zero) begin
            n_phase = i_tag.neg_i ? PI_Q13 : '0;
        end else if (i_tag.i_zero) begin
            n_phase = i_tag.neg_q ? -HALF_PI_Q13 : HALF_PI_Q13;
        end else if (!i_tag.neg_i) begin
            n_phase = i_tag.neg_q ? -a : a;
        end else begin
            n_phase = i_tag.neg_q ? (a - PI_Q13) : (PI_Q13 - a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_phase <= n_phase;
            r_last  <= i_tag.last;
        end
    end

    assign o_valid = r_valid;
    assign o_phase = r_phase;
    assign o_last  = r_last;

endmodule

FILE: hdl/iq_phase_angle.sv
// Top level of the I/Q phase angle block: a pipelined CORDIC atan2.
//
//   Port group           Direction  Handshake
//   -------------------  ---------  ---------------------------------------
//   request (I, Q, last) in         start high and busy low at a clock edge
//   result (angle, last) out        o_valid high for one cycle, no stall
//
// A request is registered in one input stage, in CORDIC_STEPS iteration
// stages (no more than the arctangent table holds) and in one output stage
// on its way to the result. One request can be taken in every cycle while
// busy is low; the iteration stages are unrolled and each holds one sample.
// The reset is synchronous and active low; it clears the valid bits of every
// stage and holds busy high until the first clock edge with i_rst_n high.
// The receiver cannot stall, so busy stays low once the block is out of reset.
//
// The first-quadrant angle atan(|Q|/|I|) is found by CORDIC vectoring on the
// magnitudes with eight guard bits and an angle accumulator in radians times
// 2^20. The output stage rounds it to Q2.13 (pi = 25736), clamps it to the
// range 0 to pi/2, and folds it into the quadrant of the sample. Samples on
// either axis bypass the CORDIC result and take their exact angle: zero for
// the positive I axis and for the zero sample, +pi for the negative I axis,
// and plus or minus pi/2 on the Q axis.
module iq_phase_angle #(
    parameter int SAMPLE_WIDTH = iqpa_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = iqpa_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample_q,
    input  logic                                i_last_sample,
    output logic                                o_valid,
    output logic signed [iqpa_pkg::PHASE_W-1:0] o_phase_angle,
    output logic                                o_last_angle
);
    import iqpa_pkg::*;

    // Vector width covers the guard bits, the CORDIC gain on a diagonal, and a sign.
    localparam int VEC_W     = SAMPLE_WIDTH + CORDIC_GUARD + 2;
    // The arctangent table ends at 24 entries; no iterations run past it.
    localparam int NUM_STEPS = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS
                                                               : ATAN_TABLE_LEN;

    logic                    r_busy;
    logic                    accept;
    logic                    s_valid [0:NUM_STEPS];
    logic signed [VEC_W-1:0] s_x     [0:NUM_STEPS];
    logic signed [VEC_W-1:0] s_y     [0:NUM_STEPS];
    t_angle                  s_z     [0:NUM_STEPS];
    t_tag                    s_tag   [0:NUM_STEPS];

    // Busy only covers the reset period, since every stage advances each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    iqpa_prep #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .VEC_W        (VEC_W)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sample_i (i_sample_i),
        .i_sample_q (i_sample_q),
        .i_last     (i_last_sample),
        .o_valid    (s_valid[0]),
        .o_x        (s_x[0]),
        .o_y        (s_y[0]),
        .o_tag      (s_tag[0])
    );

    // The angle accumulator starts at zero for every sample.
    assign s_z[0] = '0;

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        iqpa_cordic_stage #(
            .VEC_W (VEC_W),
            .STEP  (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_x     (s_x[k]),
            .i_y     (s_y[k]),
            .i_z     (s_z[k]),
            .i_tag   (s_tag[k]),
            .o_valid (s_valid[k+1]),
            .o_x     (s_x[k+1]),
            .o_y     (s_y[k+1]),
            .o_z     (s_z[k+1]),
            .o_tag   (s_tag[k+1])
        );
    end

    iqpa_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[NUM_STEPS]),
        .i_z     (s_z[NUM_STEPS]),
        .i_tag   (s_tag[NUM_STEPS]),
        .o_valid (o_valid),
        .o_phase (o_phase_angle),
        .o_last  (o_last_angle)
    );

endmodule

FILE: hdl/iqpa_checker.sv
// Port-level checker for the phase angle block, bound to its top level.
`include "assert_macros.svh"

module iqpa_checker #(
    parameter int SAMPLE_WIDTH = iqpa_pkg::SAMPLE_WIDTH_DEF,
    parameter int LATENCY      = iqpa_pkg::CORDIC_STEPS_DEF + 2
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [SAMPLE_WIDTH-1:0]      i_sample_q,
    input logic                                i_last_sample,
    input logic                                o_valid,
    input logic signed [iqpa_pkg::PHASE_W-1:0] o_phase_angle,
    input logic                                o_last_angle
);
    import iqpa_pkg::*;

    logic accepted;
    logic q_axis_req;
    logic axis_angle;

    assign accepted   = start && !busy;
    assign q_axis_req = accepted && (i_sample_q == '0);
    assign axis_angle = (o_phase_angle == '0) || (o_phase_angle == PI_Q13);

    // Every request yields exactly one result after the fixed latency.
    `IQPA_ASSERT_IMPL(a_result_follows, accepted, ##LATENCY o_valid)
    `IQPA_ASSERT_IMPL(a_no_stray_result, o_valid, $past(accepted, LATENCY))

    // The last flag of a result is the one given with its request.
    `IQPA_ASSERT_IMPL(a_last_kept, o_valid, o_last_angle == $past(i_last_sample, LATENCY))

    // Samples on the I axis give exactly zero or plus pi.
    `IQPA_ASSERT_IMPL(a_i_axis, o_valid && $past(q_axis_req, LATENCY), axis_angle)

    // Once a clock edge with i_rst_n high has passed, busy is low and stays low.
    `IQPA_ASSERT_IMPL(a_busy_low, $past(i_rst_n), !busy)

endmodule

bind iq_phase_angle iqpa_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .LATENCY      (((CORDIC_STEPS < iqpa_pkg::ATAN_TABLE_LEN) ? CORDIC_STEPS
                                                              : iqpa_pkg::ATAN_TABLE_LEN) + 2)
) u_iqpa_checker (.*);

FILE: test/iq_phase_angle_test.sv
// Self-checking testbench for the iq_phase_angle CORDIC atan2 block.
`timescale 1ns / 100ps

module iq_phase_angle_test;

    import iqpa_pkg::*;

    // The block under test runs at its default sizes, and the predictor uses
    // the same ones.
    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int LATENCY     = STEPS + 2;
    localparam int CYCLE_LIMIT = 100000;

    // Sender idle rates for the three phases of the random stimulus.
    localparam int unsigned IDLE_FIRST  = 36;
    localparam int unsigned IDLE_SECOND = 45;
    localparam int unsigned IDLE_NONE   = 0;

    // One pending request for the driver. A request with pause set carries no
    // sample: the driver stops there until every expected angle has arrived.
    typedef struct {
        logic signed [SW-1:0] si;
        logic signed [SW-1:0] sq;
        logic                 last;
        int unsigned          idle_pct;
        bit                   pause;
    } t_phase_req;

    // One predicted result.
    typedef struct {
        logic signed [PHASE_W-1:0] angle;
        logic                      last;
    } t_phase_result;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      start         = 1'b0;
    logic signed [SW-1:0]      i_sample_i    = '0;
    logic signed [SW-1:0]      i_sample_q    = '0;
    logic                      i_last_sample = 1'b0;
    logic                      busy;
    logic                      o_valid;
    logic signed [PHASE_W-1:0] o_phase_angle;
    logic                      o_last_angle;

    t_phase_req    pending_requests[$];
    t_phase_result expected_angles[$];

    int fail_count     = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int axis_count     = 0;
    int last_count     = 0;
    int pause_count    = 0;
    int cycle_count    = 0;

    // atan(2^-k) in radians scaled by 2^20, rounded to nearest.
    longint atan_q20 [0:23] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    iq_phase_angle dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample_i    (i_sample_i),
        .i_sample_q    (i_sample_q),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .o_phase_angle (o_phase_angle),
        .o_last_angle  (o_last_angle)
    );

    always #4 i_clk = ~i_clk;

    // Expected phase of one sample in Q2.13 radians. Samples on an axis take
    // their exact angle. All others get the first-quadrant angle from CORDIC
    // vectoring on the magnitudes, which is then folded into the quadrant.
    function automatic logic signed [PHASE_W-1:0] atan2_q13(
        input logic signed [SW-1:0] si,
        input logic signed [SW-1:0] sq
    );
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint mag_i;
        longint mag_q;
        logic signed [PHASE_W-1:0] quad;
        if (sq == 0) begin
            return (si < 0) ? PI_Q13 : '0;
        end
        if (si == 0) begin
            return (sq > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
        end
        // The widening happens before negation, so the most negative sample
        // keeps its full magnitude.
        mag_i = longint'(si);
        mag_q = longint'(sq);
        if (mag_i < 0) mag_i = -mag_i;
        if (mag_q < 0) mag_q = -mag_q;
        x = mag_i <<< CORDIC_GUARD;
        y = mag_q <<< CORDIC_GUARD;
        z = 0;
        for (int k = 0; k < STEPS && k < ATAN_TABLE_LEN; k++) begin
            // Both shifts use the old vector, and they round toward minus
            // infinity.
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q20[k];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q20[k];
            end
        end
        if (z < 0) z = 0;
        z = (z + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (z > longint'(HALF_PI_Q13)) z = longint'(HALF_PI_Q13);
        quad = PHASE_W'(z);
        if (si > 0) begin
            return (sq > 0) ? quad : -quad;
        end
        return (sq > 0) ? (PI_Q13 - quad) : (quad - PI_Q13);
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic add_request(
        input logic signed [SW-1:0] si,
        input logic signed [SW-1:0] sq,
        input logic                 last,
        input int unsigned          idle_pct
    );
        t_phase_req r;
        r.si       = si;
        r.sq       = sq;
        r.last     = last;
        r.idle_pct = idle_pct;
        r.pause    = 1'b0;
        pending_requests.push_back(r);
    endtask

    task automatic add_pause();
        t_phase_req r;
        r.si       = '0;
        r.sq       = '0;
        r.last     = 1'b0;
        r.idle_pct = 0;
        r.pause    = 1'b1;
        pending_requests.push_back(r);
    endtask

    // Random samples of several shapes: full-range values, tiny magnitudes,
    // full-scale components, samples close to or on an axis, equal
    // magnitudes (the diagonal), and small-angle ratios.
    task automatic add_random_requests(input int count, input int unsigned idle_pct);
        int unsigned          kind;
        int unsigned          mag;
        int unsigned          sh;
        logic signed [SW-1:0] si;
        logic signed [SW-1:0] sq;
        logic signed [SW-1:0] tmp;
        repeat (count) begin
            kind = $urandom_range(9);
            si   = SW'($urandom);
            sq   = SW'($urandom);
            case (kind)
                4: begin
                    si = SW'($urandom_range(16) - 8);
                    sq = SW'($urandom_range(16) - 8);
                end
                5: begin
                    tmp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    if ($urandom_range(1)) si = tmp;
                    else sq = tmp;
                end
                6: begin
                    if ($urandom_range(1)) sq = SW'($urandom_range(6) - 3);
                    else si = SW'($urandom_range(6) - 3);
                end
                7: begin
                    mag = $urandom_range(32768, 1);
                    si  = $urandom_range(1) ? SW'(mag) : SW'(-mag);
                    sq  = $urandom_range(1) ? SW'(mag) : SW'(-mag);
                end
                8: begin
                    if ($urandom_range(1)) si = '0;
                    else sq = '0;
                end
                9: begin
                    sh = $urandom_range(15, 4);
                    sq = si >>> sh;
                    if ($urandom_range(1)) sq = -sq;
                    if ($urandom_range(1)) begin
                        tmp = si;
                        si  = sq;
                        sq  = tmp;
                    end
                end
                default: begin
                end
            endcase
            add_request(si, sq, $urandom_range(7) == 0, idle_pct);
        end
    endtask

    // Driver. A request is accepted at the edge where start is high and busy
    // is low; its prediction is stored at that edge from the values that were
    // on the ports. Then it either holds the request, offers the next one, or
    // idles. The value of start is worked out first and assigned once, so it
    // stays high without a glitch across back-to-back requests.
    always @(posedge i_clk) begin
        t_phase_req    nxt;
        t_phase_result res;
        logic          took;
        logic          drive;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                res.angle = atan2_q13(i_sample_i, i_sample_q);
                res.last  = i_last_sample;
                expected_angles.push_back(res);
                accepted_count++;
                if (i_sample_i == 0 || i_sample_q == 0) axis_count++;
                if (i_last_sample) last_count++;
            end
            if (!(start && !took)) begin
                drive = 1'b0;
                if (pending_requests.size() > 0) begin
                    nxt = pending_requests[0];
                    if (nxt.pause) begin
                        // The pipeline must drain completely before the next
                        // request goes in.
                        if (!took && expected_angles.size() == 0) begin
                            void'(pending_requests.pop_front());
                            pause_count++;
                        end
                    end else if ($urandom_range(99) >= nxt.idle_pct) begin
                        void'(pending_requests.pop_front());
                        drive         = 1'b1;
                        i_sample_i    <= nxt.si;
                        i_sample_q    <= nxt.sq;
                        i_last_sample <= nxt.last;
                    end
                end
                start <= drive;
            end
        end
    end

    // Monitor. A result is on the ports for exactly one cycle and is taken at
    // the edge that ends that cycle; it is compared against the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_phase_result want;
        if (i_rst_n && o_valid) begin
            if (expected_angles.size() == 0) begin
                report_mismatch($sformatf("result with none expected, angle %0d last %0b",
                                          o_phase_angle, o_last_angle));
            end else begin
                want = expected_angles.pop_front();
                checked_count++;
                if (o_phase_angle !== want.angle) begin
                    report_mismatch($sformatf("result %0d: angle %0d, expected %0d",
                                              checked_count, o_phase_angle, want.angle));
                end
                if (o_last_angle !== want.last) begin
                    report_mismatch($sformatf("result %0d: last flag %0b, expected %0b",
                                              checked_count, o_last_angle, want.last));
                end
            end
        end
    end

    // Watchdog: a stuck handshake or missing results end the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_angles.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // Directed samples: the origin, both ends of both axes, full-scale
        // corners (the most negative value included), unit vectors in every
        // quadrant, and steep and shallow angles next to the axes.
        add_request(16'sd0,      16'sd0,      1'b0, IDLE_FIRST);
        add_request(16'sd1,      16'sd0,      1'b1, IDLE_FIRST);
        add_request(-16'sd1,     16'sd0,      1'b0, IDLE_FIRST);
        add_request(16'sd0,      16'sd1,      1'b1, IDLE_FIRST);
        add_request(16'sd0,      -16'sd1,     1'b0, IDLE_FIRST);
        add_request(16'sd32767,  16'sd0,      1'b0, IDLE_FIRST);
        add_request(16'sh8000,   16'sd0,      1'b1, IDLE_FIRST);
        add_request(16'sd0,      16'sd32767,  1'b0, IDLE_FIRST);
        add_request(16'sd0,      16'sh8000,   1'b1, IDLE_FIRST);
        add_request(16'sd32767,  16'sd32767,  1'b0, IDLE_FIRST);
        add_request(16'sh8000,   16'sh8000,   1'b1, IDLE_FIRST);
        add_request(16'sh8000,   16'sd32767,  1'b0, IDLE_FIRST);
        add_request(16'sd32767,  16'sh8000,   1'b0, IDLE_FIRST);
        add_request(16'sd1,      16'sd1,      1'b1, IDLE_FIRST);
        add_request(-16'sd1,     16'sd1,      1'b0, IDLE_FIRST);
        add_request(-16'sd1,     -16'sd1,     1'b1, IDLE_FIRST);
        add_request(16'sd1,      -16'sd1,     1'b0, IDLE_FIRST);
        add_request(16'sd32767,  16'sd1,      1'b0, IDLE_FIRST);
        add_request(16'sd1,      16'sd32767,  1'b1, IDLE_FIRST);
        add_request(16'sh8000,   16'sd1,      1'b0, IDLE_FIRST);
        add_request(16'sh8000,   -16'sd1,     1'b1, IDLE_FIRST);
        add_request(16'sd1,      16'sh8000,   1'b0, IDLE_FIRST);
        add_request(-16'sd1,     16'sd32767,  1'b1, IDLE_FIRST);
        add_request(16'sd3,      16'sd4,      1'b0, IDLE_FIRST);

        // Random phases: sender idles often, then more often, then never.
        // The pipeline is drained completely between phases.
        add_random_requests(600, IDLE_FIRST);
        add_pause();
        add_random_requests(600, IDLE_SECOND);
        add_pause();
        add_random_requests(626, IDLE_NONE);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || start) @(posedge i_clk);
        while (expected_angles.size() > 0) @(posedge i_clk);
        // Any stray result would show up within one pipeline latency.
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Checked %0d of %0d samples: %0d on an axis, %0d flagged as block ends,",
                 checked_count, accepted_count, axis_count, last_count);
        $display("over three sender idle rates with %0d full pipeline drains, in %0d cycles.",
                 pause_count, cycle_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/iqpa_pkg.sv
hdl/iqpa_prep.sv
hdl/iqpa_cordic_stage.sv
hdl/iqpa_fold.sv
hdl/iq_phase_angle.sv
hdl/iqpa_checker.sv
test/iq_phase_angle_test.sv
